// ===== hdl/uihc_pkg.sv =====
// ----------------------------------------------------------------------------
// uihc_pkg
// Shared types, widths and helpers for the UDP/IPv4 header checksum block.
// ----------------------------------------------------------------------------
package uihc_pkg;

	localparam int unsigned DataW     = 8;
	localparam int unsigned LenW      = 16;
	localparam int unsigned SumW      = 32;
	localparam int unsigned TotLenW   = 13;
	localparam int unsigned UdpLenW   = 12;
	localparam int unsigned CsumW     = 16;
	localparam int unsigned AddrSumW  = 18;
	localparam int unsigned IpSumW    = 20;
	localparam int unsigned UdpSumW   = 34;
	localparam int unsigned CfgIdxW   = 3;
	localparam int unsigned CfgDataW  = 32;

	localparam int unsigned MAX_PAYLOAD_DEF = 4068;

	localparam logic [LenW-1:0] IP_HDR_LEN   = 16'd20;
	localparam logic [LenW-1:0] UDP_HDR_LEN  = 16'd8;
	localparam logic [7:0]      UDP_PROTO    = 8'd17;
	localparam logic [LenW-1:0] IP_VER_IHL   = 16'h4500;
	localparam logic [CsumW-1:0] CSUM_ONES   = 16'hFFFF;

	localparam logic [15:0] SRC_PORT_RST = 16'd3456;
	localparam logic [15:0] DST_PORT_RST = 16'd53;
	localparam logic [7:0]  TTL_RST      = 8'd255;
	localparam logic [15:0] IDENT_RST    = 16'd54321;

	typedef enum logic [CfgIdxW-1:0] {
		REG_SRC_ADDR  = 3'd0,
		REG_DST_ADDR  = 3'd1,
		REG_SRC_PORT  = 3'd2,
		REG_DST_PORT  = 3'd3,
		REG_TTL       = 3'd4,
		REG_IDENT     = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic [31:0]         src_addr;
		logic [31:0]         dst_addr;
		logic [15:0]         src_port;
		logic [15:0]         dst_port;
		logic [7:0]          ttl;
		logic [15:0]         ident;
		logic [AddrSumW-1:0] addr_sum;
	} cfg_t;

	// Per-datagram totals handed from the byte accumulator to the checksum stages.
	typedef struct packed {
		logic [SumW-1:0] payload_sum;
		logic [LenW-1:0] byte_count;
		logic            too_long;
	} snap_t;

	// Ones'-complement fold of a wide sum down to 16 bits.
	function automatic logic [CsumW-1:0] fold16(input logic [UdpSumW-1:0] s);
		logic [UdpSumW-1:0] a;
		a = {{(UdpSumW-16){1'b0}}, s[15:0]} + (s >> 16);
		a = {{(UdpSumW-16){1'b0}}, a[15:0]} + (a >> 16);
		a = {{(UdpSumW-16){1'b0}}, a[15:0]} + (a >> 16);
		return a[CsumW-1:0];
	endfunction

endpackage

// ===== hdl/uihc_intf.sv =====
// ----------------------------------------------------------------------------
// uihc_byte_if / uihc_result_if
// Valid/ready channels for payload bytes and datagram results.
// ----------------------------------------------------------------------------
interface uihc_byte_if;
	logic                         valid;
	logic                         ready;
	logic [uihc_pkg::DataW-1:0]   payload_byte;
	logic                         last_byte;

	modport source (output valid, payload_byte, last_byte, input ready);
	modport sink   (input valid, payload_byte, last_byte, output ready);
endinterface

interface uihc_result_if;
	logic                           valid;
	logic                           ready;
	logic [uihc_pkg::TotLenW-1:0]   total_length;
	logic [uihc_pkg::UdpLenW-1:0]   udp_dgram_len;
	logic [uihc_pkg::CsumW-1:0]     ip_checksum;
	logic [uihc_pkg::CsumW-1:0]     udp_checksum;
	logic                           too_long;

	modport source (output valid, total_length, udp_dgram_len, ip_checksum, udp_checksum,
		too_long, input ready);
	modport sink   (input valid, total_length, udp_dgram_len, ip_checksum, udp_checksum,
		too_long, output ready);
endinterface

// ===== hdl/uihc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// uihc_cfg_regs
// Configuration register file with a registered address partial sum.
// ----------------------------------------------------------------------------
module uihc_cfg_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [uihc_pkg::CfgIdxW-1:0]    cfg_index,
	input  logic [uihc_pkg::CfgDataW-1:0]   cfg_wdata,
	output uihc_pkg::cfg_t                  cfg
);

	logic [31:0]                      src_addr_q;
	logic [31:0]                      dst_addr_q;
	logic [15:0]                      src_port_q;
	logic [15:0]                      dst_port_q;
	logic [7:0]                       ttl_q;
	logic [15:0]                      ident_q;
	logic [uihc_pkg::AddrSumW-1:0]    addr_sum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_addr_q <= '0;
			dst_addr_q <= '0;
			src_port_q <= uihc_pkg::SRC_PORT_RST;
			dst_port_q <= uihc_pkg::DST_PORT_RST;
			ttl_q      <= uihc_pkg::TTL_RST;
			ident_q    <= uihc_pkg::IDENT_RST;
		end else if (cfg_wr_en) begin
			case (uihc_pkg::cfg_reg_t'(cfg_index))
				uihc_pkg::REG_SRC_ADDR: src_addr_q <= cfg_wdata;
				uihc_pkg::REG_DST_ADDR: dst_addr_q <= cfg_wdata;
				uihc_pkg::REG_SRC_PORT: src_port_q <= cfg_wdata[15:0];
				uihc_pkg::REG_DST_PORT: dst_port_q <= cfg_wdata[15:0];
				uihc_pkg::REG_TTL:      ttl_q      <= cfg_wdata[7:0];
				uihc_pkg::REG_IDENT:    ident_q    <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_sum_q <= '0;
		end else begin
			addr_sum_q <= uihc_pkg::AddrSumW'(src_addr_q[31:16]) +
				uihc_pkg::AddrSumW'(src_addr_q[15:0]) +
				uihc_pkg::AddrSumW'(dst_addr_q[31:16]) +
				uihc_pkg::AddrSumW'(dst_addr_q[15:0]);
		end
	end

	assign cfg.src_addr = src_addr_q;
	assign cfg.dst_addr = dst_addr_q;
	assign cfg.src_port = src_port_q;
	assign cfg.dst_port = dst_port_q;
	assign cfg.ttl      = ttl_q;
	assign cfg.ident    = ident_q;
	assign cfg.addr_sum = addr_sum_q;

endmodule

// ===== hdl/uihc_accum.sv =====
// ----------------------------------------------------------------------------
// uihc_accum
// Running payload word sum and byte count; snapshot into s1 on the last byte.
// ----------------------------------------------------------------------------
module uihc_accum #(
	parameter int unsigned MAX_PAYLOAD = uihc_pkg::MAX_PAYLOAD_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	uihc_byte_if.sink        byte_in,
	output logic             snap_valid_s1,
	output uihc_pkg::snap_t  snap_s1,
	input  logic             snap_ready
);

	localparam int unsigned CountW = $clog2(MAX_PAYLOAD + 1);

	logic [uihc_pkg::SumW-1:0]   sum_q;
	logic [CountW-1:0]           count_q;
	logic [uihc_pkg::DataW-1:0]  held_q;
	logic                        odd_q;
	logic                        ovf_q;

	logic                        take;
	logic                        room;
	logic [uihc_pkg::LenW-1:0]   addend;
	logic [uihc_pkg::SumW-1:0]   payload;
	logic [CountW-1:0]           count_n;

	assign byte_in.ready = !snap_valid_s1 || snap_ready;
	assign take          = byte_in.valid && byte_in.ready;
	assign room          = count_q < CountW'(MAX_PAYLOAD);
	assign count_n       = room ? count_q + CountW'(1) : count_q;

	// Word to add for the final total, including a padded unpaired byte.
	always_comb begin
		if (room && odd_q) begin
			addend = {held_q, byte_in.payload_byte};
		end else if (room) begin
			addend = {byte_in.payload_byte, 8'h00};
		end else if (odd_q) begin
			addend = {held_q, 8'h00};
		end else begin
			addend = '0;
		end
	end

	assign payload = sum_q + uihc_pkg::SumW'(addend);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			count_q <= '0;
			held_q  <= '0;
			odd_q   <= 1'b0;
			ovf_q   <= 1'b0;
		end else if (take) begin
			if (byte_in.last_byte) begin
				sum_q   <= '0;
				count_q <= '0;
				held_q  <= '0;
				odd_q   <= 1'b0;
				ovf_q   <= 1'b0;
			end else if (room) begin
				count_q <= count_n;
				if (odd_q) begin
					sum_q <= payload;
					odd_q <= 1'b0;
				end else begin
					held_q <= byte_in.payload_byte;
					odd_q  <= 1'b1;
				end
			end else begin
				ovf_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snap_valid_s1 <= 1'b0;
		end else if (byte_in.ready) begin
			snap_valid_s1 <= take && byte_in.last_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (take && byte_in.last_byte) begin
			snap_s1.payload_sum <= payload;
			snap_s1.byte_count  <= uihc_pkg::LenW'(count_n);
			snap_s1.too_long    <= ovf_q || !room;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CountW'(MAX_PAYLOAD))
		else $error("byte count above maximum payload");

	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> count_q == CountW'(MAX_PAYLOAD))
		else $error("overflow flagged before payload reached maximum");

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		take && byte_in.last_byte |=> count_q == '0 && !odd_q && !ovf_q)
		else $error("running state not cleared after last byte");

	a_snap_hold: assert property (@(posedge clk) disable iff (!arst_n)
		snap_valid_s1 && !snap_ready |=> snap_valid_s1 && $stable(snap_s1))
		else $error("snapshot changed while stalled");

endmodule

// ===== hdl/uihc_csum.sv =====
// ----------------------------------------------------------------------------
// uihc_csum
// Header and pseudo-header sums (s2), then fold, complement and result register.
// ----------------------------------------------------------------------------
module uihc_csum (
	input  logic             clk,
	input  logic             arst_n,
	input  uihc_pkg::cfg_t   cfg,
	input  logic             snap_valid_s1,
	input  uihc_pkg::snap_t  snap_s1,
	output logic             snap_ready,
	uihc_result_if.source    result_out
);

	logic [uihc_pkg::LenW-1:0]      tot_len;
	logic [uihc_pkg::LenW-1:0]      udp_len;

	logic                           valid_s2;
	logic [uihc_pkg::IpSumW-1:0]    ip_sum_s2;
	logic [uihc_pkg::UdpSumW-1:0]   udp_sum_s2;
	logic [uihc_pkg::TotLenW-1:0]   tot_len_s2;
	logic [uihc_pkg::UdpLenW-1:0]   udp_len_s2;
	logic                           too_long_s2;
	logic                           ready_s2;

	logic                           out_valid_q;
	logic [uihc_pkg::CsumW-1:0]     udp_csum;

	assign ready_s2   = !out_valid_q || result_out.ready;
	assign snap_ready = !valid_s2 || ready_s2;

	assign tot_len = uihc_pkg::IP_HDR_LEN + uihc_pkg::UDP_HDR_LEN + snap_s1.byte_count;
	assign udp_len = uihc_pkg::UDP_HDR_LEN + snap_s1.byte_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (snap_ready) begin
			valid_s2 <= snap_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (snap_ready && snap_valid_s1) begin
			ip_sum_s2 <= uihc_pkg::IpSumW'(uihc_pkg::IP_VER_IHL) +
				uihc_pkg::IpSumW'(tot_len) +
				uihc_pkg::IpSumW'(cfg.ident) +
				uihc_pkg::IpSumW'({cfg.ttl, uihc_pkg::UDP_PROTO}) +
				uihc_pkg::IpSumW'(cfg.addr_sum);
			udp_sum_s2 <= uihc_pkg::UdpSumW'(snap_s1.payload_sum) +
				uihc_pkg::UdpSumW'(cfg.addr_sum) +
				uihc_pkg::UdpSumW'(uihc_pkg::UDP_PROTO) +
				uihc_pkg::UdpSumW'({udp_len, 1'b0}) +
				uihc_pkg::UdpSumW'(cfg.src_port) +
				uihc_pkg::UdpSumW'(cfg.dst_port);
			tot_len_s2  <= tot_len[uihc_pkg::TotLenW-1:0];
			udp_len_s2  <= udp_len[uihc_pkg::UdpLenW-1:0];
			too_long_s2 <= snap_s1.too_long;
		end
	end

	assign udp_csum = ~uihc_pkg::fold16(udp_sum_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ready_s2) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s2) begin
			result_out.total_length  <= tot_len_s2;
			result_out.udp_dgram_len <= udp_len_s2;
			result_out.ip_checksum   <= ~uihc_pkg::fold16(uihc_pkg::UdpSumW'(ip_sum_s2));
			result_out.udp_checksum  <= (udp_csum == '0) ? uihc_pkg::CSUM_ONES : udp_csum;
			result_out.too_long      <= too_long_s2;
		end
	end

	assign result_out.valid = out_valid_q;

	a_udp_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> result_out.udp_checksum != '0)
		else $error("zero UDP checksum sent");

	a_s2_advance: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && ready_s2 |=> out_valid_q)
		else $error("transaction lost between s2 and output");

	a_len_relation: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> tot_len_s2[uihc_pkg::UdpLenW-1:0] ==
			uihc_pkg::UdpLenW'(udp_len_s2 + uihc_pkg::UdpLenW'(20)))
		else $error("total length and UDP length disagree");

endmodule

// ===== hdl/udp_ipv4_header_checksum.sv =====
// ----------------------------------------------------------------------------
// udp_ipv4_header_checksum
// UDP/IPv4 length and checksum generator over a byte-wide payload stream.
// ----------------------------------------------------------------------------
// Takes one payload byte per clock while ready is high, with no gaps between
// datagrams: the byte accumulator adds one 16-bit word every second byte. The
// transaction flagged last_byte yields one result via the snapshot register,
// the sum stage and the fold into the result register. Ready drops only when
// the result register is held by the sink and both stages behind it are full.
// Configuration writes take effect on the next datagram; the user must make
// them while no datagram is in flight, which the block does not enforce.
module udp_ipv4_header_checksum #(
	parameter int unsigned MAX_PAYLOAD = uihc_pkg::MAX_PAYLOAD_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [uihc_pkg::CfgIdxW-1:0]    cfg_index,
	input  logic [uihc_pkg::CfgDataW-1:0]   cfg_wdata,
	uihc_byte_if.sink                       byte_in,
	uihc_result_if.source                   result_out
);

	uihc_pkg::cfg_t   cfg;
	uihc_pkg::snap_t  snap_s1;
	logic             snap_valid_s1;
	logic             snap_ready;

	uihc_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	uihc_accum #(
		.MAX_PAYLOAD (MAX_PAYLOAD)
	) u_accum (
		.clk           (clk),
		.arst_n        (arst_n),
		.byte_in       (byte_in),
		.snap_valid_s1 (snap_valid_s1),
		.snap_s1       (snap_s1),
		.snap_ready    (snap_ready)
	);

	uihc_csum u_csum (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.snap_valid_s1 (snap_valid_s1),
		.snap_s1       (snap_s1),
		.snap_ready    (snap_ready),
		.result_out    (result_out)
	);

endmodule
